// File: rtl/lsds_pkg.sv
package lsds_pkg;

	localparam int CHANNELS = 64;
	localparam int CH_W     = 6;
	localparam int CNT_W    = 8;
	localparam int WATCH_W  = 14;
	localparam int TPS_W    = 6;
	localparam int TMO_W    = 8;
	localparam int LIMIT_W  = TMO_W + 1 + TPS_W;

	localparam logic [WATCH_W-1:0] WATCH_MAX = {WATCH_W{1'b1}};
	localparam logic [TMO_W:0]     TMO_BIAS  = (TMO_W + 1)'(7);

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_MAX     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ON_THRESHOLD  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFF_THRESHOLD = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_SEC = 2'd3;

	localparam logic [CNT_W-1:0] RST_COUNT_MAX     = 8'd18;
	localparam logic [CNT_W-1:0] RST_ON_THRESHOLD  = 8'd12;
	localparam logic [CNT_W-1:0] RST_OFF_THRESHOLD = 8'd2;
	localparam logic [TPS_W-1:0] RST_TICKS_PER_SEC = 6'd18;

	typedef struct packed {
		logic [CNT_W-1:0]   cnt;
		logic               stable;
		logic               cmd;
		logic [WATCH_W-1:0] watch;
		logic               err;
	} lsds_entry_t;

	localparam int ENTRY_W = $bits(lsds_entry_t);

	typedef struct packed {
		logic [CNT_W-1:0] count_max;
		logic [CNT_W-1:0] on_threshold;
		logic [CNT_W-1:0] off_threshold;
	} lsds_cfg_t;

	typedef struct packed {
		logic switch_on;
		logic command_set;
		logic actuator_fault;
		logic remote_mode;
	} lsds_ctrl_t;

endpackage

// File: rtl/lsds_update.sv
module lsds_update (
	input  lsds_pkg::lsds_cfg_t                   cfg,
	input  lsds_pkg::lsds_ctrl_t                  ctrl,
	input  logic [lsds_pkg::WATCH_W-1:0]          limit,
	input  lsds_pkg::lsds_entry_t                 old_entry,
	output lsds_pkg::lsds_entry_t                 new_entry,
	output logic                                  alarm
);
	import lsds_pkg::*;

	always_comb begin
		lsds_entry_t e;
		e = old_entry;
		alarm = 1'b0;
		if (ctrl.command_set) begin
			e.cmd = 1'b1;
		end
		if (ctrl.switch_on) begin
			if (e.cnt < cfg.count_max) begin
				e.cnt = e.cnt + CNT_W'(1);
			end
		end else begin
			if (e.cnt != '0) begin
				e.cnt = e.cnt - CNT_W'(1);
			end
			if (e.cmd) begin
				if (e.watch < limit) begin
					e.watch = e.watch + WATCH_W'(1);
				end else if (!e.err) begin
					e.err   = 1'b1;
					e.watch = '0;
					alarm   = 1'b1;
				end
			end else begin
				if (e.watch != '0) begin
					e.watch = e.watch - WATCH_W'(1);
				end
				e.err = 1'b0;
			end
		end
		// switch confirmed
		if (e.cnt > cfg.on_threshold) begin
			e.stable = 1'b1;
			e.watch  = '0;
			e.err    = 1'b0;
			e.cmd    = 1'b0;
		end
		if (e.cnt < cfg.off_threshold) begin
			e.stable = 1'b0;
		end
		// interlocks
		if (ctrl.actuator_fault || !ctrl.remote_mode) begin
			e.cmd = 1'b0;
		end
		new_entry = e;
	end

endmodule

// File: rtl/limit_switch_debounce_supervisor.sv
// Limit-switch debounce and command supervisor for 64 actuator channels.
// Requests arrive on the item channel (item_valid / item_stall), one tick for
// one channel each; every request yields exactly one result on the result
// channel (result_valid / result_stall), in request order.
// Per-channel state (switch counter, stable, command, supervision counter,
// error) sits in one synchronous state memory: read when the request is
// taken, updated and written back when the update stage passes it on. A write to the same channel
// as the following request is forwarded, so any channel order runs at full
// rate.
// Throughput: one request per cycle while result_stall is low. A request passes the
// update stage register (valid_s1) and then the result register, which raises
// result_valid; the result is taken when result_stall is low.
// When result_stall holds the result register, the update stage keeps its
// request and item_stall rises while it is full; a second request waits.
// Reset clears the per-entry valid bits, so every channel reads as all zero
// from the first cycle; configuration returns to its defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while no request is in flight, which the block does not enforce.
module limit_switch_debounce_supervisor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lsds_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [lsds_pkg::CNT_W-1:0]          cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [lsds_pkg::CH_W-1:0]           channel,
	input  logic                                switch_on,
	input  logic                                command_set,
	input  logic                                actuator_fault,
	input  logic                                remote_mode,
	input  logic [lsds_pkg::TMO_W-1:0]          timeout_sec,
	input  logic [3:0]                          unit_number,
	input  logic [9:0]                          message_number,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [lsds_pkg::CH_W-1:0]           channel_out,
	output logic                                stable_flag,
	output logic                                command_out,
	output logic                                error_flag,
	output logic                                alarm_pulse,
	output logic [3:0]                          alarm_unit,
	output logic [9:0]                          alarm_message,
	output logic [lsds_pkg::CNT_W-1:0]          switch_count,
	output logic [lsds_pkg::WATCH_W-1:0]        watch_count
);
	import lsds_pkg::*;

	lsds_cfg_t          cfg_q;
	logic [TPS_W-1:0]   tps_q;

	logic               accept;
	logic               s1_go;
	logic [LIMIT_W-1:0] limit_full;
	logic [WATCH_W-1:0] limit_sat;

	logic               valid_s1;
	logic [CH_W-1:0]    ch_s1;
	lsds_ctrl_t         ctrl_s1;
	logic [3:0]         unit_s1;
	logic [9:0]         msg_s1;
	logic [WATCH_W-1:0] limit_s1;
	logic               hit_s1;
	lsds_entry_t        rd_s1;

	logic [ENTRY_W-1:0] state_mem_q [CHANNELS];
	logic [CHANNELS-1:0] entry_vld_q;

	logic               wb_valid_q;
	logic [CH_W-1:0]    wb_ch_q;
	lsds_entry_t        wb_entry_q;

	lsds_entry_t        old_entry;
	lsds_entry_t        new_entry;
	logic               alarm;

	logic               res_valid_q;
	logic [CH_W-1:0]    res_ch_q;
	lsds_entry_t        res_entry_q;
	logic               res_alarm_q;
	logic [3:0]         res_unit_q;
	logic [9:0]         res_msg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_max     <= RST_COUNT_MAX;
			cfg_q.on_threshold  <= RST_ON_THRESHOLD;
			cfg_q.off_threshold <= RST_OFF_THRESHOLD;
			tps_q               <= RST_TICKS_PER_SEC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNT_MAX:     cfg_q.count_max     <= cfg_data;
				REG_ON_THRESHOLD:  cfg_q.on_threshold  <= cfg_data;
				REG_OFF_THRESHOLD: cfg_q.off_threshold <= cfg_data;
				REG_TICKS_PER_SEC: tps_q               <= cfg_data[TPS_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign accept     = item_valid && !item_stall;
	assign s1_go      = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !s1_go;

	// supervision limit, saturated to the counter range
	assign limit_full = LIMIT_W'({1'b0, timeout_sec} + TMO_BIAS) * LIMIT_W'(tps_q);
	assign limit_sat  = (limit_full > LIMIT_W'(WATCH_MAX)) ? WATCH_MAX
		: limit_full[WATCH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1                  <= channel;
			ctrl_s1.switch_on      <= switch_on;
			ctrl_s1.command_set    <= command_set;
			ctrl_s1.actuator_fault <= actuator_fault;
			ctrl_s1.remote_mode    <= remote_mode;
			unit_s1                <= unit_number;
			msg_s1                 <= message_number;
			limit_s1               <= limit_sat;
			hit_s1                 <= entry_vld_q[channel];
			rd_s1                  <= lsds_entry_t'(state_mem_q[channel]);
		end
		if (s1_go) begin
			state_mem_q[ch_s1] <= ENTRY_W'(new_entry);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			wb_valid_q  <= 1'b0;
		end else if (s1_go) begin
			entry_vld_q[ch_s1] <= 1'b1;
			wb_valid_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			wb_ch_q    <= ch_s1;
			wb_entry_q <= new_entry;
		end
	end

	// forward the last write-back over the memory read
	always_comb begin
		if (wb_valid_q && (wb_ch_q == ch_s1)) begin
			old_entry = wb_entry_q;
		end else if (hit_s1) begin
			old_entry = rd_s1;
		end else begin
			old_entry = '0;
		end
	end

	lsds_update u_update (
		.cfg       (cfg_q),
		.ctrl      (ctrl_s1),
		.limit     (limit_s1),
		.old_entry (old_entry),
		.new_entry (new_entry),
		.alarm     (alarm)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			res_ch_q    <= ch_s1;
			res_entry_q <= new_entry;
			res_alarm_q <= alarm;
			res_unit_q  <= alarm ? unit_s1 : '0;
			res_msg_q   <= alarm ? msg_s1 : '0;
		end
	end

	assign result_valid  = res_valid_q;
	assign channel_out   = res_ch_q;
	assign stable_flag   = res_entry_q.stable;
	assign command_out   = res_entry_q.cmd;
	assign error_flag    = res_entry_q.err;
	assign alarm_pulse   = res_alarm_q;
	assign alarm_unit    = res_unit_q;
	assign alarm_message = res_msg_q;
	assign switch_count  = res_entry_q.cnt;
	assign watch_count   = res_entry_q.watch;

endmodule
